[rtl/core/bcmb_pkg.sv]
// ----------------------------------------------------------------------------
// bcmb_pkg
// Shared types and constants for the background change mask / bounding box
// block: beat payload structs, size limits, register indexes, tracker structs.
// ----------------------------------------------------------------------------
package bcmb_pkg;

   // Frame size limits
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int LINE_BITS  = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS  = 10;
   localparam int ADDR_BITS  = LINE_BITS + COL_BITS;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_BITS   = 24;

   // Configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 10;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANGE_THRESHOLD = 2'd2;

   localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RESET  = 10'd512;
   localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RESET = 10'd512;
   localparam logic [7:0]           THRESHOLD_RESET    = 8'd16;

   // Tracker start values: min trackers sit at the far frame edge
   localparam logic [COL_BITS-1:0]  COL_LAST  = COL_BITS'(MAX_WIDTH - 1);
   localparam logic [LINE_BITS-1:0] LINE_LAST = LINE_BITS'(MAX_HEIGHT - 1);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       new_sequence;
   } req_type;

   typedef struct packed {
      logic       changed;
      logic       frame_end;
      logic [8:0] box_x;
      logic [8:0] box_y;
      logic [9:0] box_width;
      logic [9:0] box_height;
      logic [9:0] largest_width;
      logic [9:0] largest_height;
   } rsp_type;

   // Per-pixel info handed to the box tracker
   typedef struct packed {
      logic                 changed;
      logic                 first_frame;
      logic                 new_sequence;
      logic                 frame_end;
      logic [COL_BITS-1:0]  column;
      logic [LINE_BITS-1:0] line;
   } track_in_type;

   // Box report for the current pixel
   typedef struct packed {
      logic [COL_BITS-1:0]  box_x;
      logic [LINE_BITS-1:0] box_y;
      logic [SIZE_BITS-1:0] box_width;
      logic [SIZE_BITS-1:0] box_height;
      logic [SIZE_BITS-1:0] largest_width;
      logic [SIZE_BITS-1:0] largest_height;
   } box_report_type;

endpackage

[rtl/core/bcmb_box_track.sv]
// ----------------------------------------------------------------------------
// bcmb_box_track
// Bounding box and peak size tracking over changed pixels. Produces the
// frame-end report for the pixel in flight; state moves on each advance.
// ----------------------------------------------------------------------------
module bcmb_box_track (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  bcmb_pkg::track_in_type  track_in,
   output bcmb_pkg::box_report_type report
);
   import bcmb_pkg::*;

   logic [COL_BITS-1:0]  min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [LINE_BITS-1:0] min_line_ff, min_line_in, max_line_ff, max_line_in;
   logic                 any_ff, any_in;
   logic [SIZE_BITS-1:0] peak_w_ff, peak_w_in, peak_h_ff, peak_h_in;

   // Tracker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_col_ff  <= COL_LAST;
         max_col_ff  <= '0;
         min_line_ff <= LINE_LAST;
         max_line_ff <= '0;
         any_ff      <= 1'b0;
         peak_w_ff   <= '0;
         peak_h_ff   <= '0;
      end else if (advance) begin
         min_col_ff  <= min_col_in;
         max_col_ff  <= max_col_in;
         min_line_ff <= min_line_in;
         max_line_ff <= max_line_in;
         any_ff      <= any_in;
         peak_w_ff   <= peak_w_in;
         peak_h_ff   <= peak_h_in;
      end
   end

   // Sequence restart, box update, frame-end report and box clear
   always_comb begin
      logic [SIZE_BITS-1:0] bw;
      logic [SIZE_BITS-1:0] bh;
      min_col_in  = min_col_ff;
      max_col_in  = max_col_ff;
      min_line_in = min_line_ff;
      max_line_in = max_line_ff;
      any_in      = any_ff;
      peak_w_in   = peak_w_ff;
      peak_h_in   = peak_h_ff;
      report      = '0;
      bw          = '0;
      bh          = '0;

      if (track_in.new_sequence) begin
         min_col_in  = COL_LAST;
         max_col_in  = '0;
         min_line_in = LINE_LAST;
         max_line_in = '0;
         any_in      = 1'b0;
         peak_w_in   = '0;
         peak_h_in   = '0;
      end

      if (track_in.changed) begin
         any_in = 1'b1;
         if (track_in.column < min_col_in) min_col_in = track_in.column;
         if (track_in.column > max_col_in) max_col_in = track_in.column;
         if (track_in.line < min_line_in) min_line_in = track_in.line;
         if (track_in.line > max_line_in) max_line_in = track_in.line;
      end

      if (track_in.frame_end) begin
         if (!track_in.first_frame && any_in) begin
            bw = SIZE_BITS'({1'b0, max_col_in} - {1'b0, min_col_in} + 1'b1);
            bh = SIZE_BITS'({1'b0, max_line_in} - {1'b0, min_line_in} + 1'b1);
            report.box_x      = min_col_in;
            report.box_y      = min_line_in;
            report.box_width  = bw;
            report.box_height = bh;
            if (bw > peak_w_in) peak_w_in = bw;
            if (bh > peak_h_in) peak_h_in = bh;
         end
         report.largest_width  = peak_w_in;
         report.largest_height = peak_h_in;
         min_col_in  = COL_LAST;
         max_col_in  = '0;
         min_line_in = LINE_LAST;
         max_line_in = '0;
         any_in      = 1'b0;
      end
   end

endmodule

[rtl/core/background_change_mask_bbox.sv]
// ----------------------------------------------------------------------------
// background_change_mask_bbox
// Pipeline: an accepted req beat passes the background read register, then the
// output register, before it can leave as its rsp beat. One pixel per cycle
// unless rsp_stall holds the pipe; each pixel costs one access (write in the
// background frame, read otherwise) on the single-port background memory.
// Reset: counters, box trackers and handshake state clear; the background
// memory is not cleared and holds nothing meaningful until a first frame.
// ----------------------------------------------------------------------------
module background_change_mask_bbox (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bcmb_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bcmb_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write_en,
   input  logic [bcmb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [bcmb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import bcmb_pkg::*;

   // Configuration registers
   logic [SIZE_BITS-1:0] frame_width_ff, frame_height_ff;
   logic [7:0]           threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         threshold_ff    <= THRESHOLD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:      frame_width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT:     frame_height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_CHANGE_THRESHOLD: threshold_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Effective frame size: zero acts as one, saturate at the maximum
   logic [SIZE_BITS-1:0] width_eff, height_eff;
   assign width_eff  = (frame_width_ff == '0) ? SIZE_BITS'(1) :
                       (frame_width_ff > SIZE_BITS'(MAX_WIDTH)) ? SIZE_BITS'(MAX_WIDTH) :
                       frame_width_ff;
   assign height_eff = (frame_height_ff == '0) ? SIZE_BITS'(1) :
                       (frame_height_ff > SIZE_BITS'(MAX_HEIGHT)) ? SIZE_BITS'(MAX_HEIGHT) :
                       frame_height_ff;

   // Handshake and pipeline control
   logic req_accept, s1_adv, s1_valid_ff, s1_valid_in, rsp_valid_ff, rsp_valid_in;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   // Raster position and background-frame flag
   logic [COL_BITS-1:0]  col_ff, col_in, col_cur;
   logic [LINE_BITS-1:0] line_ff, line_in, line_cur;
   logic                 first_ff, first_in, first_cur;
   logic                 col_last, line_last, frame_end;

   always_comb begin
      col_cur   = req_data.new_sequence ? '0 : col_ff;
      line_cur  = req_data.new_sequence ? '0 : line_ff;
      first_cur = req_data.new_sequence ? 1'b1 : first_ff;
      col_last  = (SIZE_BITS'(col_cur) + 1'b1) >= width_eff;
      line_last = (SIZE_BITS'(line_cur) + 1'b1) >= height_eff;
      frame_end = col_last && line_last;

      col_in   = col_ff;
      line_in  = line_ff;
      first_in = first_ff;
      if (req_accept) begin
         col_in   = col_last ? '0 : col_cur + 1'b1;
         line_in  = col_last ? (line_last ? '0 : line_cur + 1'b1) : line_cur;
         first_in = frame_end ? 1'b0 : first_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         first_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Background memory: write in the background frame, read otherwise
   logic [PIX_BITS-1:0]  bg_store [STORE_DEPTH];
   logic [PIX_BITS-1:0]  bg_rd_ff;
   logic [ADDR_BITS-1:0] mem_addr;
   logic                 mem_we, mem_re;

   assign mem_addr = {line_cur, col_cur};
   assign mem_we   = req_accept && first_cur;
   assign mem_re   = req_accept && !first_cur;

   always_ff @(posedge clock) begin
      if (mem_we) bg_store[mem_addr] <= {req_data.red, req_data.green, req_data.blue};
      if (mem_re) bg_rd_ff <= bg_store[mem_addr];
   end

   // Stage 1 pixel context
   logic [7:0]           s1_red_ff, s1_green_ff, s1_blue_ff;
   logic                 s1_first_ff, s1_new_seq_ff, s1_frame_end_ff;
   logic [COL_BITS-1:0]  s1_col_ff;
   logic [LINE_BITS-1:0] s1_line_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_red_ff       <= req_data.red;
         s1_green_ff     <= req_data.green;
         s1_blue_ff      <= req_data.blue;
         s1_first_ff     <= first_cur;
         s1_new_seq_ff   <= req_data.new_sequence;
         s1_frame_end_ff <= frame_end;
         s1_col_ff       <= col_cur;
         s1_line_ff      <= line_cur;
      end
   end

   // Largest channel difference against the background
   logic [7:0] diff_r, diff_g, diff_b, diff_rg, diff_max;
   logic       pix_changed;

   always_comb begin
      diff_r   = (s1_red_ff > bg_rd_ff[23:16]) ? s1_red_ff - bg_rd_ff[23:16]
                                               : bg_rd_ff[23:16] - s1_red_ff;
      diff_g   = (s1_green_ff > bg_rd_ff[15:8]) ? s1_green_ff - bg_rd_ff[15:8]
                                                : bg_rd_ff[15:8] - s1_green_ff;
      diff_b   = (s1_blue_ff > bg_rd_ff[7:0]) ? s1_blue_ff - bg_rd_ff[7:0]
                                              : bg_rd_ff[7:0] - s1_blue_ff;
      diff_rg  = (diff_g > diff_r) ? diff_g : diff_r;
      diff_max = (diff_b > diff_rg) ? diff_b : diff_rg;
      pix_changed = !s1_first_ff && (diff_max > threshold_ff);
   end

   // Box tracking
   track_in_type   track_in;
   box_report_type report;

   assign track_in.changed      = pix_changed;
   assign track_in.first_frame  = s1_first_ff;
   assign track_in.new_sequence = s1_new_seq_ff;
   assign track_in.frame_end    = s1_frame_end_ff;
   assign track_in.column       = s1_col_ff;
   assign track_in.line         = s1_line_ff;

   bcmb_box_track u_box_track (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_adv),
      .track_in (track_in),
      .report   (report)
   );

   // Output register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff.changed        <= pix_changed;
         rsp_ff.frame_end      <= s1_frame_end_ff;
         rsp_ff.box_x          <= report.box_x;
         rsp_ff.box_y          <= report.box_y;
         rsp_ff.box_width      <= report.box_width;
         rsp_ff.box_height     <= report.box_height;
         rsp_ff.largest_width  <= report.largest_width;
         rsp_ff.largest_height <= report.largest_height;
      end
   end

   assign rsp_data = rsp_ff;

   // Checks
   a_box_zero_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_end |->
         rsp_ff.box_width == '0 && rsp_ff.box_height == '0 &&
         rsp_ff.largest_width == '0 && rsp_ff.largest_height == '0)
      else $error("box fields nonzero off frame end");

   a_peak_covers_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_end |->
         rsp_ff.largest_width >= rsp_ff.box_width &&
         rsp_ff.largest_height >= rsp_ff.box_height)
      else $error("peak size below current box");

   a_no_change_in_background: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_first_ff |-> !pix_changed)
      else $error("changed pixel in background frame");

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted pixel lost before stage 1");

endmodule

[sim/background_change_mask_bbox_tb.sv]
// ----------------------------------------------------------------------------
// background_change_mask_bbox_tb
// Self-checking bench for the background subtraction / motion box block.
// A generator plans whole frames (background, near-background with a moving
// patch, broken sequences, sizes shrunk mid-frame) into a pixel backlog. A
// clocked driver sends the beats with random gaps and scores each accepted
// pixel against a local model of the block. A clocked monitor stalls the
// result side at random and checks every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module background_change_mask_bbox_tb;
   import bcmb_pkg::*;

   localparam int RANDOM_PIXELS = 200;
   localparam int SETTLE_CYCLES = 4;

   // DUT connections
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   background_change_mask_bbox DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Bench bookkeeping
   req_type pixel_backlog[$];
   rsp_type pending_reports[$];
   int      pixels_unaccepted = 0;
   int      pixels_sent = 0;
   int      mismatches = 0;
   int      frames_reported = 0;
   int      changed_pixels = 0;
   int      settings_used = 0;
   int      send_gap = 0;
   int      recv_hold = 0;
   bit      idle_on = 1'b1;

   // Register copy shared by model and generator
   logic [9:0] cfg_width = FRAME_WIDTH_RESET;
   logic [9:0] cfg_height = FRAME_HEIGHT_RESET;
   logic [7:0] cfg_threshold = THRESHOLD_RESET;

   // Model state
   logic [23:0]          learned_background [0:MAX_WIDTH*MAX_HEIGHT-1];
   bit                   in_background = 1'b1;
   logic [COL_BITS-1:0]  cur_col = '0;
   logic [LINE_BITS-1:0] cur_line = '0;
   logic [COL_BITS-1:0]  min_col = COL_LAST;
   logic [COL_BITS-1:0]  max_col = '0;
   logic [LINE_BITS-1:0] min_line = LINE_LAST;
   logic [LINE_BITS-1:0] max_line = '0;
   bit                   any_change = 1'b0;
   logic [9:0]           peak_w = '0;
   logic [9:0]           peak_h = '0;

   // Generator state
   logic [23:0] planned_background [int];
   int gen_col = 0;
   int gen_line = 0;
   bit gen_background = 1'b1;
   bit gen_frame_closed = 1'b0;
   bit wide_box = 1'b0;
   bit rect_on = 1'b0;
   int rect_x0, rect_x1, rect_y0, rect_y1;

   // Zero acts as one, oversize saturates
   function automatic int usable_size(logic [9:0] v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic logic [7:0] chan_gap(logic [7:0] a, logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void clear_bounds();
      min_col    = COL_LAST;
      max_col    = '0;
      min_line   = LINE_LAST;
      max_line   = '0;
      any_change = 1'b0;
   endfunction

   // Mask bit and frame box report for one accepted pixel
   function automatic rsp_type score_pixel(req_type px);
      rsp_type     rpt;
      int          w, h, addr;
      logic [7:0]  gap_max, d;
      logic [23:0] bg;
      bit          frame_done;
      rpt = '0;
      w = usable_size(cfg_width, MAX_WIDTH);
      h = usable_size(cfg_height, MAX_HEIGHT);
      if (px.new_sequence) begin
         in_background = 1'b1;
         cur_col  = '0;
         cur_line = '0;
         clear_bounds();
         peak_w = '0;
         peak_h = '0;
      end
      addr = cur_line * MAX_WIDTH + cur_col;
      if (in_background) begin
         learned_background[addr] = {px.red, px.green, px.blue};
      end else begin
         bg      = learned_background[addr];
         gap_max = chan_gap(px.red, bg[23:16]);
         d       = chan_gap(px.green, bg[15:8]);
         if (d > gap_max) gap_max = d;
         d = chan_gap(px.blue, bg[7:0]);
         if (d > gap_max) gap_max = d;
         if (gap_max > cfg_threshold) begin
            rpt.changed = 1'b1;
            any_change  = 1'b1;
            if (cur_col < min_col) min_col = cur_col;
            if (cur_col > max_col) max_col = cur_col;
            if (cur_line < min_line) min_line = cur_line;
            if (cur_line > max_line) max_line = cur_line;
         end
      end
      // raster advance against the current size
      frame_done = 1'b0;
      if (cur_col + 1 >= w) begin
         cur_col = '0;
         if (cur_line + 1 >= h) begin
            cur_line   = '0;
            frame_done = 1'b1;
         end else begin
            cur_line++;
         end
      end else begin
         cur_col++;
      end
      if (frame_done) begin
         rpt.frame_end = 1'b1;
         if (!in_background && any_change) begin
            rpt.box_x      = min_col;
            rpt.box_y      = min_line;
            rpt.box_width  = 10'(max_col - min_col + 1);
            rpt.box_height = 10'(max_line - min_line + 1);
            if (rpt.box_width > peak_w) peak_w = rpt.box_width;
            if (rpt.box_height > peak_h) peak_h = rpt.box_height;
         end
         rpt.largest_width  = peak_w;
         rpt.largest_height = peak_h;
         in_background = 1'b0;
         clear_bounds();
      end
      return rpt;
   endfunction

   function automatic void compare_field(string label, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endfunction

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Driver: pixel beats from the backlog, scored when accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_reports.push_back(score_pixel(req_data));
            pixels_unaccepted--;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pixel_backlog.pop_front();
               if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random result stalls, field checks against the oldest report
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, expected none, actual %p",
                        $time, rsp_data);
            end else begin
               want = pending_reports.pop_front();
               compare_field("changed", 10'(want.changed), 10'(rsp_data.changed));
               compare_field("frame_end", 10'(want.frame_end), 10'(rsp_data.frame_end));
               compare_field("box_x", 10'(want.box_x), 10'(rsp_data.box_x));
               compare_field("box_y", 10'(want.box_y), 10'(rsp_data.box_y));
               compare_field("box_width", want.box_width, rsp_data.box_width);
               compare_field("box_height", want.box_height, rsp_data.box_height);
               compare_field("largest_width", want.largest_width, rsp_data.largest_width);
               compare_field("largest_height", want.largest_height, rsp_data.largest_height);
               if (want.frame_end) frames_reported++;
               if (want.changed) changed_pixels++;
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_hold = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Wait until every pixel is in and every report is out, then let it settle
   task automatic wait_idle();
      do @(posedge clock);
      while (pixels_unaccepted != 0 || pending_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_block(logic [9:0] w, logic [9:0] h, logic [7:0] t);
      wait_idle();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FRAME_WIDTH;
      csr_wdata    <= w;
      @(posedge clock);
      csr_index    <= CSR_FRAME_HEIGHT;
      csr_wdata    <= h;
      @(posedge clock);
      csr_index    <= CSR_CHANGE_THRESHOLD;
      csr_wdata    <= CSR_DATA_BITS'(t);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_width     = w;
      cfg_height    = h;
      cfg_threshold = t;
      settings_used++;
   endtask

   // Queue one pixel and follow the raster position on the generator side
   task automatic emit_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit seq);
      req_type px;
      if (seq) begin
         gen_col        = 0;
         gen_line       = 0;
         gen_background = 1'b1;
      end
      if (gen_background) planned_background[gen_line * MAX_WIDTH + gen_col] = {r, g, b};
      px.red          = r;
      px.green        = g;
      px.blue         = b;
      px.new_sequence = seq;
      pixel_backlog.push_back(px);
      pixels_unaccepted++;
      pixels_sent++;
      gen_frame_closed = 1'b0;
      if (gen_col + 1 >= usable_size(cfg_width, MAX_WIDTH)) begin
         gen_col = 0;
         if (gen_line + 1 >= usable_size(cfg_height, MAX_HEIGHT)) begin
            gen_line         = 0;
            gen_frame_closed = 1'b1;
            gen_background   = 1'b0;
         end else begin
            gen_line++;
         end
      end else begin
         gen_col++;
      end
   endtask

   // Moving patch for the next frame: none, whole frame, or a random box
   task automatic pick_rect();
      int w, h;
      w = usable_size(cfg_width, MAX_WIDTH);
      h = usable_size(cfg_height, MAX_HEIGHT);
      rect_on = 1'b1;
      rect_x0 = 0;
      rect_x1 = w - 1;
      rect_y0 = 0;
      rect_y1 = h - 1;
      if (!wide_box) begin
         case ($urandom_range(0, 4))
            0: begin
               rect_on = 1'b0;
            end
            1: begin
            end
            default: begin
               rect_x0 = $urandom_range(0, w - 1);
               rect_x1 = $urandom_range(rect_x0, w - 1);
               rect_y0 = $urandom_range(0, h - 1);
               rect_y1 = $urandom_range(rect_y0, h - 1);
            end
         endcase
      end
   endtask

   // Background pixels are random; later ones stay within the threshold
   // of the background except inside the patch and for stray noise
   task automatic emit_scene_pixel(bit seq);
      logic [23:0] base, color;
      int          ch, v, d;
      if (seq || gen_background) begin
         color = 24'($urandom);
      end else begin
         if (gen_col == 0 && gen_line == 0) pick_rect();
         base = planned_background[gen_line * MAX_WIDTH + gen_col];
         if ((rect_on && gen_col >= rect_x0 && gen_col <= rect_x1 &&
              gen_line >= rect_y0 && gen_line <= rect_y1) || $urandom_range(0, 31) == 0) begin
            color = 24'($urandom);
         end else begin
            for (ch = 0; ch < 3; ch++) begin
               d = $urandom_range(0, cfg_threshold);
               v = int'(base[ch*8 +: 8]);
               v = $urandom_range(0, 1) ? v + d : v - d;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               color[ch*8 +: 8] = 8'(v);
            end
         end
      end
      emit_pixel(color[23:16], color[15:8], color[7:0], seq);
   endtask

   task automatic finish_frame();
      do emit_scene_pixel(1'b0);
      while (!gen_frame_closed);
   endtask

   // Stimulus
   initial begin
      int         random_start, frames, size, w_eff, h_eff;
      logic [9:0] w_reg, h_reg;
      logic [7:0] t_reg;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: first frame after reset is background without a start flag
      program_block(10'd3, 10'd2, 8'd16);
      emit_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      emit_pixel(8'h80, 8'h80, 8'h80, 1'b0);
      emit_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      emit_pixel(8'h10, 8'h10, 8'h10, 1'b0);
      // differences of exactly the threshold and one above it
      emit_pixel(8'h10, 8'h00, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'hFF, 8'hEE, 1'b0);
      emit_pixel(8'h80, 8'h80, 8'h80, 1'b0);
      emit_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'h11, 8'hFF, 1'b0);
      emit_pixel(8'h00, 8'h10, 8'h10, 1'b0);
      // unchanged frame: empty box, maxima carried over
      emit_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      emit_pixel(8'h80, 8'h80, 8'h80, 1'b0);
      emit_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      emit_pixel(8'h10, 8'h10, 8'h10, 1'b0);
      // sequence restart in the middle of a frame
      emit_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      emit_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      emit_scene_pixel(1'b1);
      finish_frame();

      // Random sequences on small frames
      random_start = pixels_sent;
      while (pixels_sent < random_start + RANDOM_PIXELS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0:       w_reg = 10'd0;
            1:       w_reg = 10'd1;
            default: w_reg = 10'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 7))
            0:       h_reg = 10'd0;
            1:       h_reg = 10'd1;
            default: h_reg = 10'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 5))
            0:       t_reg = 8'd0;
            1:       t_reg = 8'd255;
            default: t_reg = 8'($urandom_range(1, 48));
         endcase
         program_block(w_reg, h_reg, t_reg);
         emit_scene_pixel(1'b1);
         finish_frame();
         frames = $urandom_range(1, 4);
         repeat (frames) begin
            w_eff = usable_size(cfg_width, MAX_WIDTH);
            h_eff = usable_size(cfg_height, MAX_HEIGHT);
            size  = w_eff * h_eff;
            case ($urandom_range(0, 5))
               0: begin
                  // broken frame, then a new sequence
                  repeat ($urandom_range(0, size - 1)) emit_scene_pixel(1'b0);
                  emit_scene_pixel(1'b1);
                  finish_frame();
               end
               1: begin
                  // resize the frame, never larger, while it is in progress
                  if (size > 1) begin
                     repeat ($urandom_range(1, size - 1)) emit_scene_pixel(1'b0);
                     program_block(10'($urandom_range(0, w_eff)),
                                   10'($urandom_range(0, h_eff)), cfg_threshold);
                  end
                  finish_frame();
               end
               default: begin
                  finish_frame();
               end
            endcase
         end
      end

      // Largest width, written out of range so it saturates; no idling
      idle_on  = 1'b0;
      wide_box = 1'b1;
      program_block(10'd1023, 10'd1, 8'($urandom_range(0, 32)));
      emit_scene_pixel(1'b1);
      finish_frame();
      // start a changed frame at full width, then cut it short
      repeat (8) emit_scene_pixel(1'b0);
      program_block(10'd8, 10'd1, cfg_threshold);
      finish_frame();

      wait_idle();
      $display("Run sent %0d pixels over %0d register settings: %0d frame reports, %0d changed.",
               pixels_sent, settings_used, frames_reported, changed_pixels);
      $display("Included threshold edges, restarts mid-frame, mid-frame shrinks, 512 width.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("Run timed out with %0d pixels unaccepted, %0d reports pending.",
               pixels_unaccepted, pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[background_change_mask_bbox.f]
rtl/core/bcmb_pkg.sv
rtl/core/bcmb_box_track.sv
rtl/core/background_change_mask_bbox.sv
sim/background_change_mask_bbox_tb.sv
